@@ design/pcmpn_pkg.sv @@
// ----------------------------------------------------------------------------
// pcmpn_pkg
// shared widths, constants and controller command type for the pcm16 peak
// normalizer
// ----------------------------------------------------------------------------
package pcmpn_pkg;

   localparam int SAMPLE_W = 16;
   localparam int INDEX_W = 12;
   localparam int QUOT_W = 15;
   localparam int DEFAULT_BUFFER_DEPTH = 4096;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd32767;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   typedef struct packed {
      logic load;
      logic fetch;
      logic setup;
      logic step;
      logic result;
   } cmd_type;

endpackage

@@ design/pcmpn_controller.sv @@
// ----------------------------------------------------------------------------
// pcmpn_controller
// sequences loads, buffer reads, divider steps and the result transfer
// ----------------------------------------------------------------------------
module pcmpn_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pcmpn_pkg::cmd_type cmd
);

   localparam int STEP_W = $clog2(pcmpn_pkg::QUOT_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(pcmpn_pkg::QUOT_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;
   logic              out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == ST_IDLE) && req_valid && (req_cmd == pcmpn_pkg::CMD_LOAD);
      cmd.fetch  = (state_ff == ST_IDLE) && req_valid && (req_cmd == pcmpn_pkg::CMD_FETCH);
      cmd.setup  = (state_ff == ST_SETUP);
      cmd.step   = (state_ff == ST_DIVIDE);
      cmd.result = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd.fetch) begin
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               step_ff  <= '0;
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_LAST) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ design/pcmpn_datapath.sv @@
// ----------------------------------------------------------------------------
// pcmpn_datapath
// sample buffer, count and peak tracking, radix-2 divider and result register
// ----------------------------------------------------------------------------
module pcmpn_datapath #(
   parameter int BUFFER_DEPTH = pcmpn_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pcmpn_pkg::cmd_type                    cmd,
   input  logic signed [pcmpn_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                  req_last_in,
   input  logic [pcmpn_pkg::INDEX_W-1:0]         req_fetch_index,
   output logic signed [pcmpn_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                  rsp_out_of_range,
   output logic                                  rsp_passed_unchanged
);

   localparam int SW = pcmpn_pkg::SAMPLE_W;
   localparam int IW = pcmpn_pkg::INDEX_W;
   localparam int QW = pcmpn_pkg::QUOT_W;
   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

   function automatic logic [SW-1:0] magnitude(input logic [SW-1:0] raw);
      magnitude = raw[SW-1] ? (~raw + SW'(1)) : raw;
   endfunction

   logic [SW-1:0] mem [BUFFER_DEPTH];

   logic [CW-1:0] count_ff;
   logic [SW-1:0] peak_ff;
   logic          set_complete_ff;
   logic [SW-1:0] rd_data_ff;
   logic          oor_ff;
   logic          pass_ff;
   logic          sign_ff;
   logic [QW-1:0] divisor_ff;
   logic [QW-1:0] rem_ff;
   logic [QW-1:0] low_ff;
   logic [SW-1:0] sample_out_ff;
   logic          out_of_range_ff;
   logic          passed_ff;

   logic [CW-1:0]      count_eff;
   logic [CW-1:0]      count_in;
   logic [SW-1:0]      peak_eff;
   logic [SW-1:0]      peak_in;
   logic [SW-1:0]      load_raw;
   logic [SW-1:0]      load_mag;
   logic               room;
   logic [AW-1:0]      wr_addr;
   logic [IW+AW-1:0]   addr_ext;
   logic [AW-1:0]      rd_addr;
   logic [IW+CW-1:0]   idx_ext;
   logic [IW+CW-1:0]   cnt_ext;
   logic [SW-1:0]      rd_mag;
   logic [QW-1:0]      mag_q;
   logic [2*QW-1:0]    dividend;
   logic [QW:0]        trial;
   logic [QW:0]        diff;
   logic               ge;
   logic [SW-1:0]      quot_ext;
   logic [SW-1:0]      scaled;

   // load side
   assign load_raw  = req_sample_in;
   assign load_mag  = magnitude(load_raw);
   assign count_eff = set_complete_ff ? '0 : count_ff;
   assign peak_eff  = set_complete_ff ? '0 : peak_ff;
   assign room      = count_eff < DEPTH_C;
   assign wr_addr   = count_eff[AW-1:0];
   assign count_in  = count_eff + CW'(1);
   assign peak_in   = (load_mag > peak_eff) ? load_mag : peak_eff;

   // fetch address and range check
   assign addr_ext = {{AW{1'b0}}, req_fetch_index};
   assign rd_addr  = addr_ext[AW-1:0];
   assign idx_ext  = {{CW{1'b0}}, req_fetch_index};
   assign cnt_ext  = {{IW{1'b0}}, count_ff};

   // dividend is magnitude times full scale
   assign rd_mag   = magnitude(rd_data_ff);
   assign mag_q    = rd_mag[QW-1:0];
   assign dividend = {mag_q, {QW{1'b0}}} - {{QW{1'b0}}, mag_q};

   // restoring divider step
   assign trial = {rem_ff, low_ff[QW-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign ge    = trial >= {1'b0, divisor_ff};

   assign quot_ext = {{(SW-QW){1'b0}}, low_ff};
   assign scaled   = sign_ff ? (SW'(0) - quot_ext) : quot_ext;

   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         mem[wr_addr] <= load_raw;
      end
      if (cmd.fetch) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         peak_ff         <= '0;
         set_complete_ff <= 1'b0;
      end else if (cmd.load) begin
         count_ff        <= room ? count_in : count_eff;
         peak_ff         <= room ? peak_in : peak_eff;
         set_complete_ff <= req_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         oor_ff <= idx_ext >= cnt_ext;
      end
      if (cmd.setup) begin
         pass_ff    <= (peak_ff == '0) || (peak_ff >= pcmpn_pkg::FULL_SCALE);
         sign_ff    <= rd_data_ff[SW-1];
         divisor_ff <= peak_ff[QW-1:0];
         rem_ff     <= dividend[2*QW-1:QW];
         low_ff     <= dividend[QW-1:0];
      end
      if (cmd.step) begin
         rem_ff <= ge ? diff[QW-1:0] : trial[QW-1:0];
         low_ff <= {low_ff[QW-2:0], ge};
      end
      if (cmd.result) begin
         sample_out_ff   <= oor_ff ? '0 : (pass_ff ? rd_data_ff : scaled);
         out_of_range_ff <= oor_ff;
         passed_ff       <= !oor_ff && pass_ff;
      end
   end

   assign rsp_sample_out       = sample_out_ff;
   assign rsp_out_of_range     = out_of_range_ff;
   assign rsp_passed_unchanged = passed_ff;

endmodule

@@ design/pcm16_peak_normalizer_unit.sv @@
// ----------------------------------------------------------------------------
// pcm16_peak_normalizer_unit
// buffers a set of signed 16-bit samples and returns them scaled to full scale
// ----------------------------------------------------------------------------
// A load transfer is accepted in the idle state and the block is ready again
// in the next cycle. A fetch transfer runs through these steps before the
// block accepts another item: the buffer read, then forming the dividend,
// then 15 steps of the radix-2 restoring divider that computes
// (|sample| * 32767) / peak, and last the load of the result register. The
// result register lets the next item be accepted while a result still waits;
// if an earlier result still waits when a fetch reaches the result load, that
// fetch holds there until the waiting result is transferred.
// ----------------------------------------------------------------------------
module pcm16_peak_normalizer_unit #(
   parameter int BUFFER_DEPTH = pcmpn_pkg::DEFAULT_BUFFER_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic signed [pcmpn_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                  req_last_in,
   input  logic [pcmpn_pkg::INDEX_W-1:0]         req_fetch_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pcmpn_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                  rsp_out_of_range,
   output logic                                  rsp_passed_unchanged
);

   pcmpn_pkg::cmd_type cmd;

   pcmpn_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pcmpn_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_sample_in        (req_sample_in),
      .req_last_in          (req_last_in),
      .req_fetch_index      (req_fetch_index),
      .rsp_sample_out       (rsp_sample_out),
      .rsp_out_of_range     (rsp_out_of_range),
      .rsp_passed_unchanged (rsp_passed_unchanged)
   );

endmodule
